### hdl/gpce_pkg.sv
`default_nettype none
package gpce_pkg;

	localparam int COORD_W    = 8;
	localparam int SQ_W       = 15;
	localparam int D2_W       = 16;
	localparam int T_W        = 17;
	localparam int T_FRAC     = 16;
	localparam int LIN_SHIFT  = 7;
	localparam int ROOT_W     = 17;
	localparam int FRAC_SHIFT = 18;
	localparam int REM_W      = 35;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int COLOR_W    = 32;
	localparam int PROD_W     = T_W + CH_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int REG_IDX_W  = 2;

	// Mode codes; any other code paints the start color.
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_RADIAL = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_START = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_END   = 2'd2;

	localparam logic [COORD_W:0]   CENTER  = 9'd128;
	localparam logic [D2_W-1:0]    D2_UNIT = 16'd16384;
	localparam logic [T_W-1:0]     T_ONE   = 17'h10000;
	localparam logic [ACC_W-1:0]   ROUND   = ACC_W'(2 ** (T_FRAC - 1));
	localparam logic [ACC_W-1:0]   ACC_MAX = ACC_W'((2 ** CH_W - 1) * (2 ** T_FRAC));

	typedef struct packed {
		logic           blend;
		logic           radial;
		logic [T_W-1:0] lin_t;
	} gpce_side_t;

endpackage
`default_nettype wire

### hdl/gpce_coord.sv
`default_nettype none
module gpce_coord import gpce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [1:0]         paint_mode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [D2_W-1:0]    out_d2,
	output gpce_side_t         out_side
);

	logic signed [COORD_W:0]     dx, dy;
	logic signed [2*COORD_W+1:0] sqx, sqy;
	logic [COORD_W:0]            sum_xy;
	logic [T_W-1:0]              lin_t;
	logic                        valid_s1, valid_s2, rdy_s1, rdy_s2;
	logic [SQ_W-1:0]             sqx_s1, sqy_s1;
	logic [T_W-1:0]              lin_t_s1;
	logic [1:0]                  mode_s1;
	logic [D2_W-1:0]             d2, d2_s2;
	gpce_side_t                  side, side_s2;

	assign dx     = $signed({1'b0, pixel_x} - CENTER);
	assign dy     = $signed({1'b0, pixel_y} - CENTER);
	assign sqx    = dx * dx;
	assign sqy    = dy * dy;
	assign sum_xy = {1'b0, pixel_x} + {1'b0, pixel_y};
	assign lin_t  = T_W'({sum_xy, {LIN_SHIFT{1'b0}}});

	assign d2 = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	always_comb begin
		side.lin_t  = lin_t_s1;
		side.radial = 1'b0;
		side.blend  = 1'b0;
		case (mode_s1)
			MODE_LINEAR: begin
				side.blend = 1'b1;
			end
			MODE_RADIAL: begin
				side.radial = 1'b1;
				side.blend  = (d2 <= D2_UNIT);
			end
			default: begin
				side.blend = 1'b0;
			end
		endcase
	end

	assign rdy_s2   = ~valid_s2 | out_ready;
	assign rdy_s1   = ~valid_s1 | rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sqx_s1   <= sqx[SQ_W-1:0];
			sqy_s1   <= sqy[SQ_W-1:0];
			lin_t_s1 <= lin_t;
			mode_s1  <= paint_mode;
		end
		if (rdy_s2 && valid_s1) begin
			d2_s2   <= d2;
			side_s2 <= side;
		end
	end

	assign out_valid = valid_s2;
	assign out_d2    = d2_s2;
	assign out_side  = side_s2;

endmodule
`default_nettype wire

### hdl/gpce_sqrt.sv
`default_nettype none
module gpce_sqrt import gpce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [D2_W-1:0]   in_d2,
	input  gpce_side_t        in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROOT_W-1:0] out_root,
	output gpce_side_t        out_side
);

	// One result bit per stage, most significant first.
	logic              valid_s [1:ROOT_W];
	logic              rdy     [1:ROOT_W+1];
	logic [REM_W-1:0]  rem_s   [1:ROOT_W-1];
	logic [ROOT_W-1:0] root_s  [1:ROOT_W];
	gpce_side_t        side_s  [1:ROOT_W];

	assign rdy[ROOT_W+1] = out_ready;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int BIT = ROOT_W - 1 - k;

		logic [REM_W-1:0]  rem_cur, trial;
		logic [ROOT_W-1:0] root_cur, root_nxt;
		logic              valid_cur, take;
		gpce_side_t        side_cur;

		if (k == 0) begin : g_head
			assign rem_cur   = REM_W'({in_d2, {FRAC_SHIFT{1'b0}}});
			assign root_cur  = '0;
			assign valid_cur = in_valid;
			assign side_cur  = in_side;
		end else begin : g_body
			assign rem_cur   = rem_s[k];
			assign root_cur  = root_s[k];
			assign valid_cur = valid_s[k];
			assign side_cur  = side_s[k];
		end

		// (q + 2^b)^2 - q^2 = q * 2^(b+1) + 2^(2b)
		assign trial    = (REM_W'(root_cur) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
		assign take     = (rem_cur >= trial);
		assign root_nxt = take ? (root_cur | (ROOT_W'(1) << BIT)) : root_cur;

		assign rdy[k+1] = ~valid_s[k+1] | rdy[k+2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (rdy[k+1]) begin
				valid_s[k+1] <= valid_cur;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k+1] && valid_cur) begin
				root_s[k+1] <= root_nxt;
				side_s[k+1] <= side_cur;
			end
		end

		if (k < ROOT_W - 1) begin : g_rem
			logic [REM_W-1:0] rem_nxt;
			assign rem_nxt = take ? (rem_cur - trial) : rem_cur;
			always_ff @(posedge clk) begin
				if (rdy[k+1] && valid_cur) rem_s[k+1] <= rem_nxt;
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = valid_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

`ifndef SYNTHESIS
	a_root_in_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_side.radial && out_side.blend |-> out_root <= T_ONE)
		else $error("radial root above one inside the unit circle");
`endif

endmodule
`default_nettype wire

### hdl/gpce_blend.sv
`default_nettype none
module gpce_blend import gpce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ROOT_W-1:0]  in_root,
	input  gpce_side_t         in_side,
	input  logic [COLOR_W-1:0] start_color,
	input  logic [COLOR_W-1:0] end_color,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [COLOR_W-1:0] m_tdata
);

	logic [T_W-1:0]     t, t_inv;
	logic [PROD_W-1:0]  p0 [NUM_CH];
	logic [PROD_W-1:0]  p1 [NUM_CH];
	logic [PROD_W-1:0]  p0_s1 [NUM_CH];
	logic [PROD_W-1:0]  p1_s1 [NUM_CH];
	logic               valid_s1, valid_s2, blend_s1, blend_s2, rdy_s1, rdy_s2;
	logic [ACC_W-1:0]   acc [NUM_CH];
	logic [COLOR_W-1:0] mix, color_s2;

	assign t     = in_side.radial ? in_root : in_side.lin_t;
	assign t_inv = T_ONE - t;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			p1[ch] = PROD_W'(t * end_color[ch*CH_W +: CH_W]);
			p0[ch] = PROD_W'(t_inv * start_color[ch*CH_W +: CH_W]);
		end
	end

	always_comb begin
		mix = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc[ch] = ACC_W'(p0_s1[ch]) + ACC_W'(p1_s1[ch]) + ROUND;
			mix[ch*CH_W +: CH_W] = acc[ch][T_FRAC +: CH_W];
		end
	end

	assign rdy_s2   = ~valid_s2 | m_tready;
	assign rdy_s1   = ~valid_s1 | rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			p0_s1    <= p0;
			p1_s1    <= p1;
			blend_s1 <= in_side.blend;
		end
		if (rdy_s2 && valid_s1) begin
			color_s2 <= blend_s1 ? mix : start_color;
			blend_s2 <= blend_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = color_s2;

`ifndef SYNTHESIS
	a_acc_range_lo: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && blend_s1 |-> (ACC_W'(p0_s1[0]) + ACC_W'(p1_s1[0])) <= ACC_MAX)
		else $error("blend weight sum out of range on lowest channel");
	a_acc_range_hi: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && blend_s1 |->
		(ACC_W'(p0_s1[NUM_CH-1]) + ACC_W'(p1_s1[NUM_CH-1])) <= ACC_MAX)
		else $error("blend weight sum out of range on highest channel");
	a_solid_color: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !blend_s2 |-> m_tdata == start_color)
		else $error("unblended pixel differs from start color");
`endif

endmodule
`default_nettype wire

### hdl/gradient_paint_color_eval.sv
`default_nettype none
// Pipeline from an accepted input transaction to its output transaction:
// 2 coordinate stages, 17 square-root stages, 2 blend stages.
// Throughput: one pixel per cycle unless the output stalls; each square-root
// stage resolves one root bit. Stages advance independently, so bubbles close up
// while the output stalls. Reset: arst_n is asynchronous, active low; it clears
// all valid bits and the mode and color registers to zero.
module gradient_paint_color_eval import gpce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [7:0] pixel_x, [15:8] pixel_y
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [COLOR_W-1:0]   m_tdata,   // [31:0] pixel_color
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data
);

	logic [1:0]         mode_q;
	logic [COLOR_W-1:0] start_q, end_q;

	logic               c_valid, c_ready;
	logic [D2_W-1:0]    c_d2;
	gpce_side_t         c_side;
	logic               r_valid, r_ready;
	logic [ROOT_W-1:0]  r_root;
	gpce_side_t         r_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			start_q <= '0;
			end_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_START: start_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gpce_coord u_coord (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.pixel_x    (s_tdata[7:0]),
		.pixel_y    (s_tdata[15:8]),
		.paint_mode (mode_q),
		.out_valid  (c_valid),
		.out_ready  (c_ready),
		.out_d2     (c_d2),
		.out_side   (c_side)
	);

	gpce_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_d2     (c_d2),
		.in_side   (c_side),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_root  (r_root),
		.out_side  (r_side)
	);

	gpce_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (r_valid),
		.in_ready    (r_ready),
		.in_root     (r_root),
		.in_side     (r_side),
		.start_color (start_q),
		.end_color   (end_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire

### test/gradient_paint_color_eval_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module gradient_paint_color_eval_tb import gpce_pkg::*;;

	localparam logic [1:0]           MODE_SOLID = 2'd0;
	localparam logic [1:0]           MODE_SPARE = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE  = 2'd3;
	localparam int N_DIR      = 19;
	localparam int N_PHASES   = 12;
	localparam int PHASE_LEN  = 150;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 30;

	typedef struct {
		logic [1:0]         mode;
		logic [COLOR_W-1:0] c0;
		logic [COLOR_W-1:0] c1;
		logic [7:0]         x;
		logic [7:0]         y;
		bit                 typed;
		logic [COLOR_W-1:0] want;
	} paint_case_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [7:0] pixel_x, [15:8] pixel_y
	logic                 m_tvalid;
	logic                 m_tready;
	logic [COLOR_W-1:0]   m_tdata;   // [31:0] pixel_color
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [COLOR_W-1:0]   cfg_data;

	// Shadow copies of the paint registers.
	logic [1:0]         mode_r;
	logic [COLOR_W-1:0] start_r;
	logic [COLOR_W-1:0] end_r;

	logic [COLOR_W-1:0] pending_colors [$];
	logic [COLOR_W-1:0] want_color;
	paint_case_t        dir_cases [N_DIR];
	int                 errors;
	int                 idle_cycles;
	bit                 quiet_phase;

	gradient_paint_color_eval uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic logic [COLOR_W-1:0] blend_argb(input logic [T_W-1:0] t,
			input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1);
		logic [COLOR_W-1:0] res;
		longint unsigned    acc;
		res = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc = longint'(t) * c1[ch*8 +: 8] + (longint'(65536) - t) * c0[ch*8 +: 8];
			res[ch*8 +: 8] = 8'((acc + 32768) >> 16);
		end
		return res;
	endfunction

	function automatic logic [COLOR_W-1:0] paint_color(input logic [7:0] x, input logic [7:0] y);
		int                 dx;
		int                 dy;
		longint unsigned    d2;
		longint unsigned    root;
		logic [COLOR_W-1:0] color;
		color = start_r;
		case (mode_r)
			MODE_LINEAR: begin
				color = blend_argb(T_W'((int'(x) + int'(y)) * 128), start_r, end_r);
			end
			MODE_RADIAL: begin
				dx = int'(x) - 128;
				dy = int'(y) - 128;
				d2 = longint'(dx * dx + dy * dy);
				// Radius one and below blend; beyond it keep the start color.
				if (d2 <= 16384) begin
					root = floor_root(d2 << 18);
					if (root > 65536)
						root = 65536;
					color = blend_argb(T_W'(root), start_r, end_r);
				end
			end
			default: ;
		endcase
		return color;
	endfunction

	function automatic int pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Returns {pixel_y, pixel_x}; a third of the pixels land close to the unit circle.
	function automatic logic [15:0] pick_pixel();
		int dx;
		int dy;
		int yy;
		if ($urandom_range(0, 2) != 0)
			return 16'($urandom);
		dx = int'($urandom_range(0, 255)) - 128;
		dy = int'(floor_root(longint'(16384 - dx * dx))) + int'($urandom_range(0, 4)) - 2;
		if ($urandom_range(0, 1))
			dy = -dy;
		yy = 128 + dy;
		if (yy < 0)
			yy = 0;
		if (yy > 255)
			yy = 255;
		return {8'(yy), 8'(dx + 128)};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_MODE:  mode_r  = val[1:0];
			REG_START: start_r = val;
			REG_END:   end_r   = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_paint(input logic [COLOR_W-1:0] mode_val,
			input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1);
		reg_write(REG_MODE, mode_val);
		reg_write(REG_START, c0);
		reg_write(REG_END, c1);
		// The spare index must leave every register alone.
		reg_write(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Drop valid and hold until every expected color has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
			input bit typed, input logic [COLOR_W-1:0] typed_color);
		int gap;
		gap = quiet_phase ? 0 : pick_delay();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		do
			@(posedge clk);
		while (!s_tready);
		pending_colors.insert(pending_colors.size(), typed ? typed_color : paint_color(x, y));
		@(negedge clk);
	endtask

	initial begin : ready_gen
		int stall_left;
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!quiet_phase)
					stall_left = pick_delay();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_colors.size() == 0) begin
				report_mismatch($sformatf("pixel_color %h with nothing expected", m_tdata));
			end else begin
				want_color = pending_colors.pop_front();
				if (m_tdata !== want_color)
					report_mismatch($sformatf("pixel_color %h, expected %h",
						m_tdata, want_color));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [15:0]        pix;
		logic [COLOR_W-1:0] mode_val;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		mode_r      = MODE_SOLID;
		start_r     = '0;
		end_r       = '0;
		errors      = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;

		dir_cases = '{
			'{MODE_SOLID,  32'h00000000, 32'h00000000, 8'h00, 8'h00, 1, 32'h00000000},
			'{MODE_SOLID,  32'hFFFFFFFF, 32'h00000000, 8'hFF, 8'hFF, 1, 32'hFFFFFFFF},
			'{MODE_SOLID,  32'hFFFFFFFF, 32'h00000000, 8'h00, 8'hFF, 1, 32'hFFFFFFFF},
			'{MODE_SPARE,  32'h12345678, 32'hABCDEF01, 8'h11, 8'hC8, 1, 32'h12345678},
			'{MODE_LINEAR, 32'h00000000, 32'hFFFFFFFF, 8'h00, 8'h00, 1, 32'h00000000},
			'{MODE_LINEAR, 32'h00000000, 32'hFFFFFFFF, 8'hFF, 8'hFF, 0, 32'h0},
			'{MODE_LINEAR, 32'h00000000, 32'hFFFFFFFF, 8'hFF, 8'h00, 0, 32'h0},
			'{MODE_LINEAR, 32'hFF00FF00, 32'h00FF00FF, 8'h80, 8'h80, 0, 32'h0},
			'{MODE_LINEAR, 32'hFF00FF00, 32'h00FF00FF, 8'h01, 8'h7F, 0, 32'h0},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h80, 8'h80, 1, 32'h11223344},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h00, 8'h80, 1, 32'hAABBCCDD},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h80, 8'h00, 1, 32'hAABBCCDD},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h00, 8'h00, 1, 32'h11223344},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'hFF, 8'hFF, 1, 32'h11223344},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h00, 8'h7F, 1, 32'h11223344},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'h01, 8'h80, 0, 32'h0},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'hDA, 8'hDA, 0, 32'h0},
			'{MODE_RADIAL, 32'h11223344, 32'hAABBCCDD, 8'hFF, 8'h80, 0, 32'h0},
			'{MODE_RADIAL, 32'h00000000, 32'hFFFFFFFF, 8'h81, 8'h80, 0, 32'h0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed cases; reprogram only where the paint setup changes.
		foreach (dir_cases[i]) begin
			if (dir_cases[i].mode != mode_r || dir_cases[i].c0 != start_r ||
					dir_cases[i].c1 != end_r) begin
				drain();
				apply_paint(COLOR_W'(dir_cases[i].mode), dir_cases[i].c0, dir_cases[i].c1);
			end
			send_pixel(dir_cases[i].x, dir_cases[i].y, dir_cases[i].typed, dir_cases[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			quiet_phase = (p % 4 == 3);
			if (p < 4)
				mode_val = COLOR_W'(p);
			else if ($urandom_range(0, 5) == 0)
				mode_val = $urandom_range(0, 1) ? COLOR_W'(MODE_SOLID) : COLOR_W'(MODE_SPARE);
			else
				mode_val = $urandom_range(0, 1) ? COLOR_W'(MODE_LINEAR) : COLOR_W'(MODE_RADIAL);
			// Upper bits of the mode word carry junk.
			mode_val[COLOR_W-1:2] = 30'($urandom);
			apply_paint(mode_val, pick_color(), pick_color());
			for (int n = 0; n < PHASE_LEN; n++) begin
				pix = pick_pixel();
				send_pixel(pix[7:0], pix[15:8], 0, '0);
			end
		end

		quiet_phase = 1'b0;
		s_tvalid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
